// ----- design/cda_pkg.sv -----
// cda_pkg: widths, status codes, step-unit structs and calendar helper functions
// shared by the date advance core and its step unit; depends on nothing
`default_nettype none

package cda_pkg;

    // bounds of the advance
    localparam int MAX_YEAR = 1023;
    localparam int MAX_ADD  = 65535;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YIN_W    = 10;
    localparam int DAYS_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SERIAL_W = 19;

    // internal widths
    localparam int YEAR_W   = $clog2(MAX_YEAR + 2);
    localparam int ADD_W    = $clog2(MAX_ADD + 1);
    localparam int SER_W    = SERIAL_W + 1;
    localparam int R100_W   = 7;
    localparam int R400_W   = 9;

    // reciprocal constants for year / 100 and year / 400
    localparam int RECIP_100   = 5243;
    localparam int RECIP_400   = 1311;
    localparam int RECIP_SHIFT = 19;

    localparam int DAYS_PER_YEAR = 365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DATE = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // request to the month step unit
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [ADD_W-1:0]   days;
        logic               leap;
    } step_req_t;

    // response of the month step unit
    typedef struct packed {
        logic               fits;
        logic               year_inc;
        logic               overflow;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [ADD_W-1:0]   days;
    } step_rsp_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] cum;
        case (m)
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

`default_nettype wire

// ----- design/cda_in_if.sv -----
// cda_in_if: input channel of the date advance core, one start date and day count per beat
// depends on cda_pkg for the field widths
`default_nettype none

interface cda_in_if import cda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YIN_W-1:0]   start_year;
    logic [DAYS_W-1:0]  days_to_add;

    modport source (output valid, output start_day, output start_month,
                    output start_year, output days_to_add, input ready);
    modport sink   (input valid, input start_day, input start_month,
                    input start_year, input days_to_add, output ready);
endinterface

`default_nettype wire

// ----- design/cda_out_if.sv -----
// cda_out_if: result channel of the date advance core, one status and date per beat
// depends on cda_pkg for the field widths
`default_nettype none

interface cda_out_if import cda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DAY_W-1:0]    end_day;
    logic [MONTH_W-1:0]  end_month;
    logic [YIN_W-1:0]    end_year;
    logic [SERIAL_W-1:0] day_number;

    modport source (output valid, output status, output end_day, output end_month,
                    output end_year, output day_number, input ready);
    modport sink   (input valid, input status, input end_day, input end_month,
                    input end_year, input day_number, output ready);
endinterface

`default_nettype wire

// ----- design/calendar_date_advance_core.sv -----
// calendar_date_advance_core: top level of the gregorian date advance block
// depends on cda_pkg, cda_in_if, cda_out_if and cda_step_unit
`default_nettype none

// The core takes one beat holding a start date (day, month, year since 2000)
// and a day count, checks the date and advances it month by month with the
// 4/100/400 leap rule. Each result beat carries a status (ok, invalid date,
// year overflow), the end date and its serial day number with 2000-01-01 as
// day 1; all result fields are zero unless the status is ok. After its beat
// is taken an item goes through setup (year division, remainders, then date
// check with the start serial), then, if the date is good, steps a month at a
// time until the rest of the count fits or the year overflows, and last loads
// the result register once it is free. The month step unit is reused for every
// month. The core is not ready while an item is in work; a finished result
// waits in the output register, so the next beat is taken while the previous
// result is still unclaimed.

module calendar_date_advance_core import cda_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    cda_in_if.sink    req,
    cda_out_if.source rsp
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DIV     = 6'b000010,
        S_REM     = 6'b000100,
        S_CHECK   = 6'b001000,
        S_ADVANCE = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // working date and counters
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [ADD_W-1:0]   days_reg, days_next;
    logic [ADD_W-1:0]   add_reg, add_next;
    logic [YEAR_W-1:0]  q100_reg, q100_next;
    logic [YEAR_W-1:0]  q400_reg, q400_next;
    logic [SER_W-1:0]   y365_reg, y365_next;
    logic [R100_W-1:0]  r100_reg, r100_next;
    logic [R400_W-1:0]  r400_reg, r400_next;
    logic [SER_W-1:0]   serial_reg, serial_next;
    status_t            status_reg, status_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [DAY_W-1:0]    out_day_reg, out_day_next;
    logic [MONTH_W-1:0]  out_month_reg, out_month_next;
    logic [YIN_W-1:0]    out_year_reg, out_year_next;
    logic [SERIAL_W-1:0] out_number_reg, out_number_next;

    step_req_t step_req;
    step_rsp_t step_rsp;

    logic        leap;
    logic        bad_date;
    logic [31:0] leaps_before;
    logic [31:0] serial_sum;
    logic [31:0] prod100;
    logic [31:0] prod400;
    logic [31:0] rem100;
    logic [31:0] rem400;
    logic [SER_W-1:0] end_serial;

    // leap flag of the working year from the kept remainders
    assign leap = (year_reg[1:0] == 2'd0) && ((r100_reg != '0) || (r400_reg == '0));

    assign step_req.day   = day_reg;
    assign step_req.month = month_reg;
    assign step_req.year  = year_reg;
    assign step_req.days  = days_reg;
    assign step_req.leap  = leap;

    cda_step_unit u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.end_day    = out_day_reg;
    assign rsp.end_month  = out_month_reg;
    assign rsp.end_year   = out_year_reg;
    assign rsp.day_number = out_number_reg;

    always_comb
    begin
        // year / 100 and year / 400 by reciprocal multiply
        prod100 = 32'(year_reg) * 32'(RECIP_100);
        prod400 = 32'(year_reg) * 32'(RECIP_400);
        rem100  = 32'(year_reg) - 32'(q100_reg) * 32'd100;
        rem400  = 32'(year_reg) - 32'(q400_reg) * 32'd400;

        // leap years in 0 .. year-1: ceil(y/4) - ceil(y/100) + ceil(y/400)
        leaps_before = ((32'(year_reg) + 32'd3) >> 2) - 32'(q100_reg)
                     - 32'(r100_reg != '0) + 32'(q400_reg) + 32'(r400_reg != '0);
        serial_sum = 32'(y365_reg) + leaps_before + 32'(days_before_month(month_reg))
                   + 32'(leap && (month_reg > MONTH_FEB)) + 32'(day_reg);

        bad_date = (day_reg == '0) || (month_reg == '0) || (month_reg > MONTH_DEC)
                || (day_reg > month_len(month_reg, leap));

        end_serial = serial_reg + SER_W'(add_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        days_next       = days_reg;
        add_next        = add_reg;
        q100_next       = q100_reg;
        q400_next       = q400_reg;
        y365_next       = y365_reg;
        r100_next       = r100_reg;
        r400_next       = r400_reg;
        serial_next     = serial_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_number_next = out_number_reg;

        // result beat taken
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    day_next   = req.start_day;
                    month_next = req.start_month;
                    year_next  = YEAR_W'(req.start_year);
                    // day count saturates at the bound
                    if (32'(req.days_to_add) > MAX_ADD)
                    begin
                        days_next = ADD_W'(MAX_ADD);
                    end
                    else
                    begin
                        days_next = ADD_W'(req.days_to_add);
                    end
                    add_next   = days_next;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                q100_next  = YEAR_W'(prod100 >> RECIP_SHIFT);
                q400_next  = YEAR_W'(prod400 >> RECIP_SHIFT);
                y365_next  = SER_W'(32'(year_reg) * 32'(DAYS_PER_YEAR));
                state_next = S_REM;
            end
            S_REM:
            begin
                r100_next  = R100_W'(rem100);
                r400_next  = R400_W'(rem400);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                serial_next = SER_W'(serial_sum);
                if (bad_date)
                begin
                    status_next = STATUS_BAD_DATE;
                    state_next  = S_DONE;
                end
                else if (32'(year_reg) > MAX_YEAR)
                begin
                    status_next = STATUS_OVERFLOW;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = STATUS_OK;
                    state_next  = S_ADVANCE;
                end
            end
            S_ADVANCE:
            begin
                day_next   = step_rsp.day;
                month_next = step_rsp.month;
                year_next  = step_rsp.year;
                days_next  = step_rsp.days;
                if (step_rsp.year_inc)
                begin
                    r100_next = (r100_reg == R100_W'(99)) ? '0 : r100_reg + R100_W'(1);
                    r400_next = (r400_reg == R400_W'(399)) ? '0 : r400_reg + R400_W'(1);
                end
                if (step_rsp.overflow)
                begin
                    status_next = STATUS_OVERFLOW;
                    state_next  = S_DONE;
                end
                else if (step_rsp.fits)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // load the result register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == STATUS_OK)
                    begin
                        out_day_next    = day_reg;
                        out_month_next  = month_reg;
                        out_year_next   = YIN_W'(year_reg);
                        out_number_next = SERIAL_W'(end_serial);
                    end
                    else
                    begin
                        out_day_next    = '0;
                        out_month_next  = '0;
                        out_year_next   = '0;
                        out_number_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        day_reg        <= day_next;
        month_reg      <= month_next;
        year_reg       <= year_next;
        days_reg       <= days_next;
        add_reg        <= add_next;
        q100_reg       <= q100_next;
        q400_reg       <= q400_next;
        y365_reg       <= y365_next;
        r100_reg       <= r100_next;
        r400_reg       <= r400_next;
        serial_reg     <= serial_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_number_reg <= out_number_next;
    end

    // a failed item carries an all-zero date and serial
    property p_fail_zero;
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_OK)) |->
            ((rsp.end_day == '0) && (rsp.end_month == '0) && (rsp.end_year == '0)
             && (rsp.day_number == '0));
    endproperty
    a_fail_zero: assert property (p_fail_zero)
        else $error("failed result with nonzero fields");

    // a good result is a real date
    property p_ok_date;
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STATUS_OK)) |->
            ((rsp.end_day != '0) && (rsp.end_month != '0) && (rsp.end_month <= MONTH_DEC)
             && (rsp.day_number != '0));
    endproperty
    a_ok_date: assert property (p_ok_date)
        else $error("ok result with impossible date");

    // the remaining day count shrinks on every step that stays in the loop
    property p_advance_progress;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADVANCE) |=>
            ((state_reg != S_ADVANCE) || (days_reg < $past(days_reg)));
    endproperty
    a_advance_progress: assert property (p_advance_progress)
        else $error("advance step made no progress");

    // remainders used for the leap rule stay in range while advancing
    property p_rem_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADVANCE) |->
            ((r100_reg < R100_W'(100)) && (r400_reg < R400_W'(400)));
    endproperty
    a_rem_range: assert property (p_rem_range)
        else $error("year remainder out of range");

endmodule

`default_nettype wire

// ----- design/cda_step_unit.sv -----
// cda_step_unit: shared step of the date advance, finishes in the current month
// or moves to the first of the next one; depends on cda_pkg
`default_nettype none

module cda_step_unit import cda_pkg::*; (
    input  step_req_t req,
    output step_rsp_t rsp
);

    logic [DAY_W-1:0] mlen;
    logic [DAY_W-1:0] left;
    logic [DAY_W:0]   span;
    logic             fits;
    logic             dec;

    always_comb
    begin
        mlen = month_len(req.month, req.leap);
        left = mlen - req.day;
        span = {1'b0, left} + 6'd1;
        // the remaining days fit in this month when days <= days left
        fits = 32'(req.days) < 32'(span);
        dec  = (req.month == MONTH_DEC);

        rsp.fits     = fits;
        rsp.year_inc = !fits && dec;
        rsp.year     = req.year + YEAR_W'(rsp.year_inc);
        rsp.overflow = rsp.year_inc && (32'(rsp.year) > MAX_YEAR);
        if (fits)
        begin
            rsp.day   = req.day + DAY_W'(req.days);
            rsp.month = req.month;
            rsp.days  = '0;
        end
        else
        begin
            rsp.day   = DAY_W'(1);
            rsp.month = dec ? MONTH_JAN : req.month + MONTH_W'(1);
            rsp.days  = req.days - ADD_W'(span);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for calendar_date_advance_core, start dates and day counts
// depends on cda_pkg, cda_in_if, cda_out_if and the core itself
module tb import cda_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int unsigned RANDOM_JOBS   = 248;
    localparam int unsigned PHASE_LEN     = 95;     // accepted jobs per idling phase
    localparam int unsigned STALL_AT      = 150;    // jobs taken before the long receiver hold
    localparam int unsigned STALL_CYCLES  = 5000;
    localparam int unsigned DRAIN_AT      = 215;    // job that waits for an empty pipeline
    localparam int unsigned TAIL_CYCLES   = 2300;   // wait after drain for any stray result beat
    localparam int unsigned WATCHDOG_MAX  = 30000;

    // one start date and day count, as offered on the request channel
    typedef struct {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YIN_W-1:0]   year;
        logic [DAYS_W-1:0]  days;
        bit                 drain_first;   // hold this beat until no result is outstanding
    } date_job_t;

    // what the core should return for one job
    typedef struct packed {
        status_t             status;
        logic [DAY_W-1:0]    end_day;
        logic [MONTH_W-1:0]  end_month;
        logic [YIN_W-1:0]    end_year;
        logic [SERIAL_W-1:0] day_number;
    } date_result_t;

    logic clk = 1'b0;
    logic rst_n;

    cda_in_if  req_if ();
    cda_out_if rsp_if ();

    calendar_date_advance_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    date_job_t    jobs_q[$];        // jobs not yet offered
    date_result_t predicted_q[$];   // results owed by the core, oldest first

    int unsigned jobs_taken;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_left;
    bit          stall_done;
    int unsigned quiet_cycles;
    int unsigned mismatches = 0;

    initial forever #1 clk = ~clk;

    // ------------------------------------------------------------------
    // calendar arithmetic, year counted from 2000
    // ------------------------------------------------------------------

    // 2000 is divisible by 400, so the plain gregorian rule holds on the offset
    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // walks the date forward a month at a time, then forms the serial day
    function automatic date_result_t advance_date(logic [DAY_W-1:0] sd,
                                                  logic [MONTH_W-1:0] sm,
                                                  logic [YIN_W-1:0] sy,
                                                  logic [DAYS_W-1:0] add);
        date_result_t r;
        int unsigned  d, m, y, n, left, doy, k;
        r = '0;
        d = sd;
        m = sm;
        y = sy;
        n = add;
        if (n > MAX_ADD)
            n = MAX_ADD;
        // bad date: zero day, month out of range, or day past the month's end
        if (d == 0 || m < 1 || m > 12 || d > days_in_month(m, y)) begin
            r.status = STATUS_BAD_DATE;
            return r;
        end
        // start year already past the bound
        if (y > MAX_YEAR) begin
            r.status = STATUS_OVERFLOW;
            return r;
        end
        while (n > 0) begin
            left = days_in_month(m, y) - d;
            if (n <= left) begin
                d = d + n;
                n = 0;
            end
            else begin
                n = n - (left + 1);
                d = 1;
                m = m + 1;
                if (m > 12) begin
                    m = 1;
                    y = y + 1;
                    // rolled past the last representable year
                    if (y > MAX_YEAR) begin
                        r.status = STATUS_OVERFLOW;
                        return r;
                    end
                end
            end
        end
        doy = d;
        for (k = 1; k < m; k++)
            doy = doy + days_in_month(k, y);
        r.status    = STATUS_OK;
        r.end_day   = d[DAY_W-1:0];
        r.end_month = m[MONTH_W-1:0];
        r.end_year  = y[YIN_W-1:0];
        // leap years in 0..y-1 are the multiples of 4, less those of 100, plus those of 400;
        // counting from year 0 gives ceiling divisions
        r.day_number = SERIAL_W'(365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + doy);
        return r;
    endfunction

    task automatic push_job(int unsigned d, int unsigned m, int unsigned y, int unsigned n);
        date_job_t j;
        j.day         = d[DAY_W-1:0];
        j.month       = m[MONTH_W-1:0];
        j.year        = y[YIN_W-1:0];
        j.days        = n[DAYS_W-1:0];
        j.drain_first = 1'b0;
        jobs_q.push_back(j);
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // idling: sender 30 / receiver 63 percent, then swapped, then none
    // ------------------------------------------------------------------
    always_comb begin
        if (jobs_taken < PHASE_LEN) begin
            send_idle_pct = 30;
            recv_idle_pct = 63;
        end
        else if (jobs_taken < 2 * PHASE_LEN) begin
            send_idle_pct = 63;
            recv_idle_pct = 30;
        end
        else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // ------------------------------------------------------------------
    // request driver: a beat stays put until taken, then the next job
    // from the queue may follow in the next cycle
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : request_driver
        date_job_t j;
        logic      offer;
        if (!rst_n) begin
            req_if.valid       <= 1'b0;
            req_if.start_day   <= '0;
            req_if.start_month <= '0;
            req_if.start_year  <= '0;
            req_if.days_to_add <= '0;
            jobs_taken         <= 0;
        end
        else begin
            // accepted beat: predict its result right away
            if (req_if.valid && req_if.ready) begin
                predicted_q.push_back(advance_date(req_if.start_day, req_if.start_month,
                                                   req_if.start_year, req_if.days_to_add));
                jobs_taken <= jobs_taken + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                offer = 1'b0;
                if (jobs_q.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(jobs_q[0].drain_first && predicted_q.size() != 0)) begin
                    j = jobs_q.pop_front();
                    req_if.start_day   <= j.day;
                    req_if.start_month <= j.month;
                    req_if.start_year  <= j.year;
                    req_if.days_to_add <= j.days;
                    offer = 1'b1;
                end
                req_if.valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random ready, plus one long hold so the core fills
    // its output register and stops taking beats
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : result_receiver
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            stall_done   <= 1'b0;
        end
        else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (!stall_done && jobs_taken >= STALL_AT) begin
            stall_left   <= STALL_CYCLES;
            stall_done   <= 1'b1;
            rsp_if.ready <= 1'b0;
        end
        else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every taken beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        date_result_t want;
        if (rst_n === 1'b1 && rsp_if.valid && rsp_if.ready) begin
            if (predicted_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, status %0d day %0d",
                         $time, rsp_if.status, rsp_if.end_day);
                mismatches++;
            end
            else begin
                want = predicted_q.pop_front();
                check_field("status",     want.status,     rsp_if.status);
                check_field("end_day",    want.end_day,    rsp_if.end_day);
                check_field("end_month",  want.end_month,  rsp_if.end_month);
                check_field("end_year",   want.end_year,   rsp_if.end_year);
                check_field("day_number", want.day_number, rsp_if.day_number);
            end
        end
    end

    // watchdog: too long with no beat on either channel ends the run
    always @(posedge clk) begin : watchdog
        if (rst_n !== 1'b1 || (req_if.valid && req_if.ready)
            || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned d, m, y, n, pick;
        rst_n = 1'b0;

        // directed: boundaries, leap rule, rollover, bad dates, overflow
        push_job(1, 1, 0, 0);          // first serial day
        push_job(31, 12, 0, 0);        // last day of a leap year
        push_job(28, 2, 0, 1);         // into a leap day
        push_job(28, 2, 1, 1);         // common february rolls into march
        push_job(28, 2, 100, 1);       // century, not leap
        push_job(29, 2, 100, 0);       // century leap day does not exist
        push_job(29, 2, 400, 0);       // fourth century is leap
        push_job(29, 2, 1, 0);         // leap day in a common year
        push_job(30, 2, 4, 0);         // past end of a leap february
        push_job(31, 4, 7, 3);         // past end of a 30-day month
        push_job(0, 5, 10, 5);         // zero day
        push_job(10, 0, 10, 5);        // zero month
        push_job(10, 13, 10, 5);       // month just past december
        push_job(31, 15, 1023, 65535); // all ones
        push_job(31, 1, 0, 1);         // month rollover
        push_job(31, 12, 5, 1);        // year rollover
        push_job(31, 12, 1023, 0);     // last date in range
        push_job(31, 12, 1023, 1);     // overflow by one day
        push_job(1, 1, 1023, 364);     // end of the last year
        push_job(1, 1, 0, 65535);      // largest count from the first day
        push_job(1, 1, 900, 65535);    // largest count runs out of years
        push_job(15, 6, 512, 30);      // mid-year, exact month length

        // random: mostly well-formed dates, a share of raw field values
        for (int i = 0; i < RANDOM_JOBS; i++) begin
            y    = $urandom_range(1023);
            pick = $urandom_range(99);
            if (pick < 80) begin
                m = $urandom_range(12, 1);
                // favor month ends to hit rollover often
                d = ($urandom_range(3) == 0) ? days_in_month(m, y)
                                             : $urandom_range(days_in_month(m, y), 1);
            end
            else begin
                m = $urandom_range(15);
                d = $urandom_range(31);
            end
            pick = $urandom_range(99);
            if (pick < 55)
                n = $urandom_range(400);
            else if (pick < 75)
                n = $urandom_range(4000);
            else if (pick < 80)
                n = 0;
            else
                n = $urandom_range(65535);
            push_job(d, m, y, n);
        end
        jobs_q[DRAIN_AT].drain_first = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (jobs_q.size() != 0 || req_if.valid || predicted_q.size() != 0)
            @(posedge clk);
        // room for any stray beat the core might still send
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
